[rtl/arl_pkg.sv]
// Package for the AES round layer unit: layer codes, S-box tables and a GF(2^8) helper.
// Used by arl_lane and aes_round_layer_unit; depends on nothing.
`default_nettype none
package arl_pkg;

    typedef enum logic [1:0] {
        ACT_SUB   = 2'd0,
        ACT_SHIFT = 2'd1,
        ACT_MIX   = 2'd2,
        ACT_PASS  = 2'd3
    } t_action;

    typedef logic [7:0] t_byte;
    typedef t_byte [3:0] t_col;

    localparam int unsigned NumLanes = 4;

    localparam logic [7:0] Sbox [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] InvSbox [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    // Multiply by x modulo x^8+x^4+x^3+x+1.
    function automatic t_byte xtime(input t_byte a);
        xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

endpackage
`default_nettype wire

[rtl/arl_lane.sv]
// One column lane: S-box lookups and MixColumns for four bytes of the state.
// Depends on arl_pkg.
`default_nettype none
module arl_lane (
    input  wire arl_pkg::t_col i_col,
    input  wire                i_inv,
    output arl_pkg::t_col      o_sub,
    output arl_pkg::t_col      o_mix
);
    import arl_pkg::*;

    t_byte x2 [4];
    t_byte x4 [4];
    t_byte x8 [4];
    t_byte m1 [4];
    t_byte m2 [4];
    t_byte m3 [4];
    t_byte m9 [4];
    t_byte mb [4];
    t_byte md [4];
    t_byte me [4];

    // Substitute each byte through the table for the direction
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            o_sub[k] = i_inv ? InvSbox[i_col[k]] : Sbox[i_col[k]];
        end
    end

    // Build the GF(2^8) multiples of each byte
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            m1[k] = i_col[k];
            x2[k] = xtime(i_col[k]);
            x4[k] = xtime(x2[k]);
            x8[k] = xtime(x4[k]);
            m2[k] = x2[k];
            m3[k] = x2[k] ^ i_col[k];
            m9[k] = x8[k] ^ i_col[k];
            mb[k] = x8[k] ^ x2[k] ^ i_col[k];
            md[k] = x8[k] ^ x4[k] ^ i_col[k];
            me[k] = x8[k] ^ x4[k] ^ x2[k];
        end
    end

    // Mix rows: coefficient for byte k in row r is row[(k - r) mod 4]
    always_comb begin
        for (int r = 0; r < 4; r++) begin
            if (i_inv) begin
                o_mix[r] = me[r] ^ mb[(r + 1) % 4] ^ md[(r + 2) % 4] ^ m9[(r + 3) % 4];
            end else begin
                o_mix[r] = m2[r] ^ m3[(r + 1) % 4] ^ m1[(r + 2) % 4] ^ m1[(r + 3) % 4];
            end
        end
    end

endmodule
`default_nettype wire

[rtl/aes_round_layer_unit.sv]
// The result strobe rises in the cycle after start; throughput: one state per cycle.
// Four column lanes do S-box and MixColumns in parallel; a merge stage selects the
// layer, applies ShiftRows and registers the result. busy is always low.
// Reset (synchronous, active low) clears the result strobe only.
// The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none
module aes_round_layer_unit (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         start,
    output logic        busy,
    input  wire  [63:0] i_state_hi,
    input  wire  [63:0] i_state_lo,
    input  wire  [1:0]  i_action,
    input  wire         i_direction,
    output logic        o_valid,
    output logic [63:0] o_result_hi,
    output logic [63:0] o_result_lo
);
    import arl_pkg::*;

    t_byte  b     [16];
    t_col   cols  [NumLanes];
    t_col   subs  [NumLanes];
    t_col   mixs  [NumLanes];
    t_byte  n_out [16];
    logic   r_valid;
    logic [127:0] r_data;
    logic [127:0] n_data;

    assign busy = 1'b0;

    // Unpack bytes into columns
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            b[i]     = i_state_hi[63 - 8 * i -: 8];
            b[i + 8] = i_state_lo[63 - 8 * i -: 8];
        end
        for (int c = 0; c < NumLanes; c++) begin
            for (int r = 0; r < 4; r++) begin
                cols[c][r] = b[r + 4 * c];
            end
        end
    end

    for (genvar g = 0; g < NumLanes; g++) begin : g_lane
        arl_lane u_lane (
            .i_col (cols[g]),
            .i_inv (i_direction),
            .o_sub (subs[g]),
            .o_mix (mixs[g])
        );
    end

    // Merge lane outputs for the chosen layer
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                case (t_action'(i_action))
                    ACT_SUB:   n_out[r + 4 * c] = subs[c][r];
                    ACT_SHIFT: n_out[r + 4 * c] = i_direction ? cols[(c + 4 - r) % 4][r]
                                                              : cols[(c + r) % 4][r];
                    ACT_MIX:   n_out[r + 4 * c] = mixs[c][r];
                    default:   n_out[r + 4 * c] = cols[c][r];
                endcase
            end
        end
        for (int i = 0; i < 16; i++) begin
            n_data[127 - 8 * i -: 8] = n_out[i];
        end
    end

    // Hold the result beat for one cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= start;
        end
        r_data <= n_data;
    end

    assign o_valid     = r_valid;
    assign o_result_hi = r_data[127:64];
    assign o_result_lo = r_data[63:0];

endmodule
`default_nettype wire

[bench/aes_round_layer_checker.sv]
// Checker for the AES round layer unit: predicts each layer result and compares it.
// Depends on arl_pkg for the layer codes; watches the DUT ports only.
`default_nettype none
module aes_round_layer_checker
    import arl_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         start,
    input  wire         busy,
    input  wire  [63:0] i_state_hi,
    input  wire  [63:0] i_state_lo,
    input  wire  [1:0]  i_action,
    input  wire         i_direction,
    input  wire         o_valid,
    input  wire  [63:0] o_result_hi,
    input  wire  [63:0] o_result_lo,
    output int          o_fail_cnt,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [127:0] expected_states [$];

    // GF(2^8) product with reduction 0x1B
    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = 8'h00;
        for (int k = 0; k < 8; k++) begin
            if (b[k]) p ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
        end
        return p;
    endfunction

    // x^254, zero maps to zero
    function automatic logic [7:0] ginv(input logic [7:0] x);
        logic [7:0] r;
        r = 8'h01;
        for (int k = 0; k < 254; k++) r = gmul(r, x);
        return r;
    endfunction

    function automatic logic [7:0] rol8(input logic [7:0] x, input int n);
        return (x << n) | (x >> (8 - n));
    endfunction

    function automatic logic [7:0] sub_byte(input logic [7:0] x, input logic inv);
        logic [7:0] v;
        if (!inv) begin
            v = ginv(x);
            return v ^ rol8(v, 1) ^ rol8(v, 2) ^ rol8(v, 3) ^ rol8(v, 4) ^ 8'h63;
        end
        v = rol8(x, 1) ^ rol8(x, 3) ^ rol8(x, 6) ^ 8'h05;
        return ginv(v);
    endfunction

    // Apply one round layer to a packed 128-bit state
    function automatic logic [127:0] round_layer(input logic [127:0] st, input t_action act,
                                                 input logic inv);
        logic [7:0] b [16];
        logic [7:0] t [16];
        logic [7:0] m [4];
        logic [7:0] acc;
        logic [127:0] res;
        for (int i = 0; i < 16; i++) b[i] = st[127 - 8*i -: 8];
        t = b;
        case (act)
            ACT_SUB: begin
                for (int i = 0; i < 16; i++) t[i] = sub_byte(b[i], inv);
            end
            ACT_SHIFT: begin
                for (int r = 0; r < 4; r++)
                    for (int c = 0; c < 4; c++)
                        if (inv) t[r + 4*((c + r) & 3)] = b[r + 4*c];
                        else     t[r + 4*c] = b[r + 4*((c + r) & 3)];
            end
            ACT_MIX: begin
                if (inv) m = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
                else     m = '{8'h02, 8'h03, 8'h01, 8'h01};
                for (int c = 0; c < 4; c++)
                    for (int r = 0; r < 4; r++) begin
                        acc = 8'h00;
                        for (int k = 0; k < 4; k++)
                            acc ^= gmul(b[k + 4*c], m[(k - r + 4) & 3]);
                        t[r + 4*c] = acc;
                    end
            end
            default: ;
        endcase
        for (int i = 0; i < 16; i++) res[127 - 8*i -: 8] = t[i];
        return res;
    endfunction

    assign o_pending = expected_states.size();

    initial o_fail_cnt = 0;

    // Predict on each accepted beat, compare each result strobe
    always @(posedge i_clk) begin
        logic [127:0] exp_st;
        int errs;
        errs = 0;
        if (i_rst_n && o_valid) begin
            if (expected_states.size() == 0) begin
                $error("result with no expected state: %h %h", o_result_hi, o_result_lo);
                errs++;
            end else begin
                exp_st = expected_states.pop_front();
                if (o_result_hi !== exp_st[127:64]) begin
                    $error("result_hi expected %h actual %h", exp_st[127:64], o_result_hi);
                    errs++;
                end
                if (o_result_lo !== exp_st[63:0]) begin
                    $error("result_lo expected %h actual %h", exp_st[63:0], o_result_lo);
                    errs++;
                end
            end
        end
        if (errs != 0)
            o_fail_cnt <= o_fail_cnt + errs;
        if (i_rst_n && start && !busy)
            expected_states.push_back(round_layer({i_state_hi, i_state_lo},
                                                  t_action'(i_action), i_direction));
    end
endmodule
`default_nettype wire

[bench/aes_round_layer_unit_tb.sv]
// Top of the AES round layer unit bench: clock, reset, stimulus and verdict.
// Depends on arl_pkg, aes_round_layer_unit and aes_round_layer_checker.
`default_nettype none
module aes_round_layer_unit_tb;
    import arl_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic [63:0] i_state_hi = '0;
    logic [63:0] i_state_lo = '0;
    logic [1:0]  i_action = ACT_PASS;
    logic        i_direction = 1'b0;
    wire         busy;
    wire         o_valid;
    wire  [63:0] o_result_hi;
    wire  [63:0] o_result_lo;
    int          fail_cnt;
    int          pending;

    always #6 i_clk = ~i_clk;

    aes_round_layer_unit DUT (.*);

    aes_round_layer_checker u_checker (
        .i_clk, .i_rst_n, .start, .busy, .i_state_hi, .i_state_lo, .i_action,
        .i_direction, .o_valid, .o_result_hi, .o_result_lo,
        .o_fail_cnt(fail_cnt), .o_pending(pending)
    );

    // Present one beat and hold it until accepted
    task automatic send_state(input logic [63:0] hi, input logic [63:0] lo,
                              input t_action act, input logic dir);
        start       <= 1'b1;
        i_state_hi  <= hi;
        i_state_lo  <= lo;
        i_action    <= act;
        i_direction <= dir;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
    endtask

    task automatic idle_cycles(input int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    function automatic logic [63:0] rand_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return {8{8'($urandom)}};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    initial begin
        int burst;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes per layer and direction, plus known-answer vectors
        for (int a = 0; a < 4; a++)
            for (int d = 0; d < 2; d++) begin
                send_state('0, '0, t_action'(a), d[0]);
                send_state('1, '1, t_action'(a), d[0]);
            end
        send_state(64'hdb135345f20a225c, 64'h0123456789abcdef, ACT_MIX, 1'b0);
        send_state(64'h8e4da1bc9fdc589d, 64'h0123456789abcdef, ACT_MIX, 1'b1);
        send_state(64'h00102030_40506070, 64'h8090a0b0_c0d0e0f0, ACT_SHIFT, 1'b0);
        send_state(64'h00112233_44556677, 64'h8899aabb_ccddeeff, ACT_SUB, 1'b1);

        // Hold off until every result has drained
        start <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (pending == 0) break;
        end

        // Random bursts with random gaps, some long runs with no gap
        burst = 0;
        for (int n = 0; n < 1450; n++) begin
            send_state(rand_word(), rand_word(), t_action'($urandom_range(0, 3)),
                       1'($urandom));
            if (burst > 0) begin
                burst--;
            end else begin
                burst = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 6);
                idle_cycles($urandom_range(1, 4));
            end
        end

        // Drain and give the verdict
        start <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (pending == 0) break;
        end
        repeat (4) @(posedge i_clk);
        if (fail_cnt == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #2ms;
        $display("DONE: errors detected");
        $finish;
    end
endmodule
`default_nettype wire
